[hw/rtl/dtt_pkg.sv]
// Shared types and constants for the deadline timer table.
`default_nettype none

package dtt_pkg;

   localparam int NOW_W      = 47;
   localparam int DL_W       = 48;
   localparam int IVAL_W     = 32;
   localparam int HANDLE_W   = 32;
   localparam int TMO_W      = 31;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;

   localparam logic [IVAL_W-1:0] MS_PER_SEC  = 32'd1000;
   localparam logic [TMO_W-1:0]  TIMEOUT_MAX = 31'h7FFF_FFFF;

   localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DEL   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_FIRE  = 2'd2;
   localparam logic [FUNC_W-1:0] FN_QUERY = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [NOW_W-1:0]    now;
      logic [IVAL_W-1:0]   ms;
      logic                rep;
      logic [HANDLE_W-1:0] handle;
   } cmd_type;

endpackage

`default_nettype wire

[hw/rtl/dtt_front.sv]
// Request intake: unpack beats, scale the interval to ms, queue commands.
`default_nettype none

module dtt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // now[46:0], interval[78:47], repeat_req[79], handle[111:80]
   input  wire logic [111:0]     req_tdata,
   // func[1:0], in_seconds[2]
   input  wire logic [2:0]       req_tuser,
   output logic                  q_valid,
   output dtt_pkg::cmd_type      q_cmd,
   input  wire logic             q_pop
);

   dtt_pkg::cmd_type  q_mem [2];
   dtt_pkg::cmd_type  cmd_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic              push;
   logic [31:0]       ival;

   assign ival        = req_tdata[78:47];
   assign req_tready  = (cnt_ff != 2'd2);
   assign push        = req_tvalid & req_tready;

   always_comb begin
      cmd_in.func   = req_tuser[1:0];
      cmd_in.now    = req_tdata[46:0];
      cmd_in.ms     = req_tuser[2] ? 32'(ival * dtt_pkg::MS_PER_SEC) : ival;
      cmd_in.rep    = req_tdata[79];
      cmd_in.handle = req_tdata[111:80];
   end

   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = q_mem[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dtt_engine.sv]
// Slot table and scan sequencer: executes one command, registers the response.
`default_nettype none

module dtt_engine #(
   parameter int TIMER_SLOTS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire dtt_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // result_handle[31:0], timeout[62:32], zero[63]
   output logic [63:0]           rsp_tdata,
   // status[1:0]
   output logic [1:0]            rsp_tuser
);

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   dtt_pkg::cmd_type        cmd_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [IDX_W-1:0]        eval_idx_ff;
   logic                    eval_vld_ff;

   logic [TIMER_SLOTS-1:0]  used_ff;
   logic [31:0]             last_handle_ff;

   logic                    mem_rep      [TIMER_SLOTS];
   logic [31:0]             mem_ival     [TIMER_SLOTS];
   logic [47:0]             mem_dl       [TIMER_SLOTS];
   logic [31:0]             mem_handle   [TIMER_SLOTS];
   logic                    rd_rep_ff;
   logic [31:0]             rd_ival_ff;
   logic [47:0]             rd_dl_ff;
   logic [31:0]             rd_handle_ff;

   logic                    found_ff;
   logic [IDX_W-1:0]        pick_ff;
   logic [47:0]             best_dl_ff;
   logic [47:0]             best_left_ff;
   logic                    best_rep_ff;
   logic [31:0]             best_ival_ff;
   logic [31:0]             best_handle_ff;

   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [31:0]             rsp_handle_ff;
   logic [30:0]             rsp_tmo_ff;

   logic [47:0]             now48;
   logic [47:0]             left;
   logic                    cur_used;
   logic                    hit;
   logic                    fin_go;
   logic [31:0]             new_handle;
   logic [31:0]             sum_ival;
   logic [47:0]             new_dl;
   logic                    wr_all;
   logic                    wr_dl;
   logic [1:0]              fin_status;
   logic [31:0]             fin_handle;
   logic [30:0]             fin_tmo;

   assign now48    = {1'b0, cmd_ff.now};
   assign left     = (rd_dl_ff > now48) ? (rd_dl_ff - now48) : 48'd0;
   assign cur_used = used_ff[eval_idx_ff];

   always_comb begin
      hit = 1'b0;
      case (cmd_ff.func)
         dtt_pkg::FN_ADD: begin
            hit = !cur_used && !found_ff;
         end
         dtt_pkg::FN_DEL: begin
            hit = cur_used && !found_ff && (cmd_ff.handle != 32'd0)
                  && (rd_handle_ff == cmd_ff.handle);
         end
         dtt_pkg::FN_FIRE: begin
            hit = cur_used && (rd_dl_ff <= now48)
                  && (!found_ff || (rd_dl_ff < best_dl_ff));
         end
         dtt_pkg::FN_QUERY: begin
            hit = cur_used && (!found_ff || (left < best_left_ff));
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign q_pop  = (state_ff == ST_IDLE) && q_valid;
   assign fin_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   assign new_handle = ((last_handle_ff + 32'd1) == 32'd0) ? 32'd1
                                                           : (last_handle_ff + 32'd1);
   assign sum_ival   = (cmd_ff.func == dtt_pkg::FN_ADD) ? cmd_ff.ms : best_ival_ff;
   assign new_dl     = now48 + {16'd0, sum_ival};
   assign wr_all     = fin_go && found_ff && (cmd_ff.func == dtt_pkg::FN_ADD);
   assign wr_dl      = wr_all
                       || (fin_go && found_ff && (cmd_ff.func == dtt_pkg::FN_FIRE)
                           && best_rep_ff);

   always_comb begin
      fin_status = dtt_pkg::ST_NONE;
      fin_handle = 32'd0;
      fin_tmo    = 31'd0;
      case (cmd_ff.func)
         dtt_pkg::FN_ADD: begin
            fin_status = found_ff ? dtt_pkg::ST_OK : dtt_pkg::ST_FULL;
            fin_handle = found_ff ? new_handle : 32'd0;
         end
         dtt_pkg::FN_DEL: begin
            if (found_ff) begin
               fin_status = dtt_pkg::ST_OK;
               fin_handle = cmd_ff.handle;
            end
         end
         dtt_pkg::FN_FIRE: begin
            if (found_ff) begin
               fin_status = dtt_pkg::ST_OK;
               fin_handle = best_handle_ff;
            end
         end
         dtt_pkg::FN_QUERY: begin
            if (found_ff) begin
               fin_status = dtt_pkg::ST_OK;
               fin_tmo    = (best_left_ff > {17'd0, dtt_pkg::TIMEOUT_MAX})
                            ? dtt_pkg::TIMEOUT_MAX : best_left_ff[30:0];
            end
         end
         default: begin
            fin_status = dtt_pkg::ST_NONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         eval_vld_ff    <= 1'b0;
         found_ff       <= 1'b0;
         used_ff        <= '0;
         last_handle_ff <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         eval_vld_ff <= (state_ff == ST_SCAN);
         if (q_pop) begin
            found_ff <= 1'b0;
         end else if (eval_vld_ff && hit) begin
            found_ff <= 1'b1;
         end
         if (wr_all) begin
            used_ff[pick_ff] <= 1'b1;
            last_handle_ff   <= new_handle;
         end
         if (fin_go && found_ff && (cmd_ff.func == dtt_pkg::FN_DEL)) begin
            used_ff[pick_ff] <= 1'b0;
         end
         if (fin_go && found_ff && (cmd_ff.func == dtt_pkg::FN_FIRE) && !best_rep_ff) begin
            used_ff[pick_ff] <= 1'b0;
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff    <= q_cmd;
         rd_idx_ff <= '0;
      end else if (state_ff == ST_SCAN && rd_idx_ff != LAST_IDX) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      eval_idx_ff <= rd_idx_ff;
      if (eval_vld_ff && hit) begin
         pick_ff        <= eval_idx_ff;
         best_dl_ff     <= rd_dl_ff;
         best_left_ff   <= left;
         best_rep_ff    <= rd_rep_ff;
         best_ival_ff   <= rd_ival_ff;
         best_handle_ff <= rd_handle_ff;
      end
      if (fin_go) begin
         rsp_status_ff <= fin_status;
         rsp_handle_ff <= fin_handle;
         rsp_tmo_ff    <= fin_tmo;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_all) begin
         mem_rep[pick_ff]    <= cmd_ff.rep;
         mem_ival[pick_ff]   <= cmd_ff.ms;
         mem_handle[pick_ff] <= new_handle;
      end
      if (wr_dl) begin
         mem_dl[pick_ff] <= new_dl;
      end
      rd_rep_ff    <= mem_rep[rd_idx_ff];
      rd_ival_ff   <= mem_ival[rd_idx_ff];
      rd_dl_ff     <= mem_dl[rd_idx_ff];
      rd_handle_ff <= mem_handle[rd_idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_tmo_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_add_sets_used: assert property (@(posedge clock) disable iff (reset)
      wr_all |=> used_ff[$past(pick_ff)])
      else $error("add did not mark its slot used");

   a_handle_nonzero: assert property (@(posedge clock) disable iff (reset)
      (last_handle_ff != 32'd0) |=> (last_handle_ff != 32'd0))
      else $error("handle counter returned to zero");

   a_scan_starts_clear: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (!found_ff && state_ff == ST_SCAN && rd_idx_ff == '0))
      else $error("scan started with stale pick");

   a_fire_due: assert property (@(posedge clock) disable iff (reset)
      (fin_go && found_ff && cmd_ff.func == dtt_pkg::FN_FIRE) |-> (best_dl_ff <= now48))
      else $error("fired a timer that is not due");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == dtt_pkg::ST_OK || rsp_status_ff == dtt_pkg::ST_FULL
                        || rsp_status_ff == dtt_pkg::ST_NONE))
      else $error("illegal status code");
`endif

endmodule

`default_nettype wire

[hw/rtl/deadline_timer_table.sv]
// Top level of the deadline timer table.
//
// Usage: one request beat on req_* carries an operation (add, delete, fire,
// query) and the current time; every request yields exactly one response
// beat on rsp_* with a status, a handle and a timeout.
// Requests land in a two-entry command queue; the engine pops one command,
// reads the slot table one slot per cycle, then updates the table and loads
// the response register.
// The engine works on one command at a time, scanning the single-port slot
// table, and pops the next command only when it is idle again.
// Reset: all slots free, handle counter zero, queue and response empty.
// Backpressure: a response waits in its register while rsp_tready is low;
// the engine holds its finished command and the queue keeps taking requests
// until both entries are full, then req_tready drops.
`default_nettype none

module deadline_timer_table #(
   parameter int TIMER_SLOTS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // now[46:0], interval[78:47], repeat_req[79], handle[111:80]
   input  wire logic [111:0]  req_tdata,
   // func[1:0], in_seconds[2]
   input  wire logic [2:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // result_handle[31:0], timeout[62:32], zero[63]
   output logic [63:0]        rsp_tdata,
   // status[1:0]
   output logic [1:0]         rsp_tuser
);

   logic              q_valid;
   logic              q_pop;
   dtt_pkg::cmd_type  q_cmd;

   dtt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   dtt_engine #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the deadline timer table: directed and random operations.
`timescale 1ns / 100ps

module testbench;
   import dtt_pkg::*;

   localparam int SLOTS       = 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [TMO_W-1:0]    tmo;
   } timer_outcome_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;   // now[46:0], interval[78:47], repeat_req[79], handle[111:80]
   logic [2:0]    req_tuser = '0;   // func[1:0], in_seconds[2]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;        // result_handle[31:0], timeout[62:32], zero[63]
   logic [1:0]    rsp_tuser;        // status[1:0]

   // Table shadow
   logic                tt_used     [SLOTS];
   logic                tt_repeat   [SLOTS];
   logic [IVAL_W-1:0]   tt_period   [SLOTS];
   logic [DL_W-1:0]     tt_deadline [SLOTS];
   logic [HANDLE_W-1:0] tt_handle   [SLOTS];
   logic [HANDLE_W-1:0] tt_last_handle = '0;

   timer_outcome_t outcome_q[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   logic [NOW_W-1:0] cur_now = '0;

   deadline_timer_table #(.TIMER_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 50)
         $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic timer_outcome_t apply_timer_op(
      input logic [FUNC_W-1:0]   func,
      input logic [NOW_W-1:0]    t_now,
      input logic [IVAL_W-1:0]   ival,
      input logic                secs,
      input logic                rep,
      input logic [HANDLE_W-1:0] h);
      timer_outcome_t      res;
      logic [IVAL_W-1:0]   ms;
      logic [HANDLE_W-1:0] nh;
      logic [DL_W-1:0]     now48;
      logic [DL_W-1:0]     left;
      logic [DL_W-1:0]     best;
      logic                any;
      int                  pick;
      res.status = ST_NONE;
      res.handle = '0;
      res.tmo    = '0;
      now48 = {1'b0, t_now};
      pick  = -1;
      any   = 1'b0;
      best  = '0;
      case (func)
         FN_ADD: begin
            res.status = ST_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               if (!tt_used[i]) begin
                  ms = secs ? ival * MS_PER_SEC : ival;
                  nh = tt_last_handle + 1'b1;
                  if (nh == '0)
                     nh = 1;
                  tt_last_handle = nh;
                  tt_repeat[i]   = rep;
                  tt_period[i]   = ms;
                  tt_deadline[i] = now48 + {16'd0, ms};
                  tt_handle[i]   = nh;
                  tt_used[i]     = 1'b1;
                  res.status     = ST_OK;
                  res.handle     = nh;
                  break;
               end
            end
         end
         FN_DEL: begin
            if (h != '0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tt_used[i] && tt_handle[i] == h) begin
                     tt_used[i] = 1'b0;
                     res.status = ST_OK;
                     res.handle = h;
                     break;
                  end
               end
            end
         end
         FN_FIRE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tt_used[i] && tt_deadline[i] <= now48)
                  if (pick < 0 || tt_deadline[i] < tt_deadline[pick])
                     pick = i;
            end
            if (pick >= 0) begin
               res.handle = tt_handle[pick];
               if (tt_repeat[pick])
                  tt_deadline[pick] = now48 + {16'd0, tt_period[pick]};
               else
                  tt_used[pick] = 1'b0;
               res.status = ST_OK;
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tt_used[i]) begin
                  left = (tt_deadline[i] > now48) ? tt_deadline[i] - now48 : '0;
                  if (!any || left < best)
                     best = left;
                  any = 1'b1;
               end
            end
            if (any) begin
               res.status = ST_OK;
               res.tmo = (best > {17'd0, TIMEOUT_MAX}) ? TIMEOUT_MAX : best[TMO_W-1:0];
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : rsp_check
      timer_outcome_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, '0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
            if (rsp_tdata[31:0] !== want.handle)
               report_mismatch("result_handle", 64'(rsp_tdata[31:0]), 64'(want.handle));
            if (rsp_tdata[62:32] !== want.tmo)
               report_mismatch("timeout", 64'(rsp_tdata[62:32]), 64'(want.tmo));
            if (rsp_tdata[63] !== 1'b0)
               report_mismatch("tdata pad", 64'(rsp_tdata[63]), 64'd0);
         end
      end
   end

   task automatic send_timer_op(input logic [FUNC_W-1:0] func, input logic [NOW_W-1:0] t_now,
                                input logic [IVAL_W-1:0] ival, input logic secs,
                                input logic rep, input logic [HANDLE_W-1:0] h);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {h, rep, ival, t_now};
      req_tuser  <= {secs, func};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      outcome_q.push_back(apply_timer_op(func, t_now, ival, secs, rep, h));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [HANDLE_W-1:0] pick_live_handle();
      int live[$];
      for (int i = 0; i < SLOTS; i++)
         if (tt_used[i])
            live.push_back(i);
      if (live.size() == 0)
         return $urandom();
      return tt_handle[live[$urandom_range(0, live.size() - 1)]];
   endfunction

   task automatic send_random_timer_op();
      logic [FUNC_W-1:0]   func;
      logic [IVAL_W-1:0]   ival;
      logic                secs;
      logic [HANDLE_W-1:0] h;
      int                  roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         func = FN_ADD;
      else if (roll < 55)
         func = FN_DEL;
      else if (roll < 85)
         func = FN_FIRE;
      else
         func = FN_QUERY;
      // advance time, with rare jumps anywhere
      if ($urandom_range(0, 99) < 3)
         cur_now = NOW_W'({$urandom(), $urandom()});
      else
         cur_now = cur_now + $urandom_range(0, 300);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         ival = $urandom_range(0, 1000);
         secs = 1'b0;
      end else if (roll < 80) begin
         ival = $urandom_range(0, 3);
         secs = 1'b1;
      end else begin
         ival = $urandom();
         secs = 1'($urandom_range(0, 1));
      end
      roll = $urandom_range(0, 99);
      if (func == FN_DEL && roll < 70)
         h = pick_live_handle();
      else if (func == FN_DEL && roll < 80)
         h = '0;
      else
         h = $urandom();
      send_timer_op(func, cur_now, ival, secs, 1'($urandom_range(0, 1)), h);
   endtask

   task automatic test_directed_edges();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_timer_op(FN_QUERY, 47'd0, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_FIRE, 47'd0, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_DEL, 47'd0, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_DEL, 47'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_timer_op(FN_ADD, 47'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0);
      // nearest deadline beyond the timeout range
      send_timer_op(FN_QUERY, 47'd0, 32'd0, 1'b0, 1'b0, 32'd0);
      // seconds scaling that wraps
      send_timer_op(FN_ADD, 47'd1000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0);
      send_timer_op(FN_ADD, 47'd2000, 32'd0, 1'b0, 1'b1, 32'd0);
      for (int i = 0; i < 5; i++)
         send_timer_op(FN_ADD, 47'd2000, $urandom_range(1, 500), 1'b0, i[0], 32'd0);
      // table full
      send_timer_op(FN_ADD, 47'd2000, 32'd5, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_FIRE, 47'd2000, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_QUERY, 47'd2000, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_DEL, 47'd2100, 32'd0, 1'b0, 1'b0, 32'd1);
      send_timer_op(FN_DEL, 47'd2100, 32'd0, 1'b0, 1'b0, 32'd1);
      // deadline past the 47-bit time range
      send_timer_op(FN_ADD, {NOW_W{1'b1}}, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd0);
      send_timer_op(FN_FIRE, {NOW_W{1'b1}}, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_FIRE, {NOW_W{1'b1}}, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_QUERY, {NOW_W{1'b1}}, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_QUERY, 47'd100, 32'd0, 1'b0, 1'b0, 32'd0);
      send_timer_op(FN_DEL, 47'd100, 32'd0, 1'b0, 1'b0, tt_last_handle);
      wait_drained();
      cur_now = 47'd10000;
   endtask

   task automatic test_streaming_no_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (125) send_random_timer_op();
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 54;
      rsp_stall_pct = 0;
      repeat (125) send_random_timer_op();
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      rsp_stall_pct = 54;
      repeat (125) send_random_timer_op();
   endtask

   task automatic test_mixed_idle();
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      repeat (125) send_random_timer_op();
   endtask

   task automatic test_pause_until_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 30;
      repeat (20) send_random_timer_op();
      wait_drained();
      repeat (20) send_random_timer_op();
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++)
         tt_used[i] = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_streaming_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idle();
      test_pause_until_drained();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_front.sv
hw/rtl/dtt_engine.sv
hw/rtl/deadline_timer_table.sv
verif/testbench.sv
